>>> rtl/srms_pkg.sv
// Package: shared types, widths and constants of the stereo RMS level meter.
package srms_pkg;

  localparam int MaxFramesDefault  = 256;
  localparam int SampleBitsDefault = 16;

  localparam int LEVEL_W   = 16;
  localparam int SQ_W      = 32;
  localparam int SUM_W     = 40;
  localparam int DIV_W     = 40;
  localparam int DVR_W     = 16;
  localparam int DIV_STEPS = DIV_W;
  localparam int ROOT_W    = 20;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SREM_W    = ROOT_W + 1;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int MUL_A_W   = LEVEL_W + 1;
  localparam int PROD_W    = MUL_A_W + LEVEL_W;
  localparam int SMOOTH_W  = PROD_W + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] SmoothingWeightReset = 16'd4588;
  localparam logic [LEVEL_W-1:0] FullScaleReset       = 16'd11141;
  localparam logic [LEVEL_W-1:0] LevelMax             = 16'hFFFF;
  localparam logic [MUL_A_W-1:0] WeightOne            = 17'h10000;
  localparam logic [SMOOTH_W-1:0] RoundHalf           = SMOOTH_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTHING_WEIGHT = 1'b0,
    REG_FULL_SCALE       = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_LOAD_RMS,
    ST_DIV_RMS,
    ST_SQRT,
    ST_MUL_OLD,
    ST_SUM,
    ST_LOAD_SCALE,
    ST_DIV_SCALE,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_RMS,
    OP_LOAD_SQRT,
    OP_MUL_NEW,
    OP_MUL_OLD,
    OP_SUM_SMOOTH,
    OP_LOAD_SCALE,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } sts_t;

endpackage

>>> rtl/srms_if.sv
// Interfaces: frame input, result output and register write channels.
interface srms_frame_if #(
  parameter int SAMPLE_BITS = srms_pkg::SampleBitsDefault
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          last_frame;

  modport source (output valid, left_sample, right_sample, last_frame, input ready);
  modport sink   (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

interface srms_result_if;
  logic                           valid;
  logic                           ready;
  logic [srms_pkg::LEVEL_W-1:0]   rms_level;
  logic [srms_pkg::LEVEL_W-1:0]   smoothed_level;
  logic [srms_pkg::LEVEL_W-1:0]   scaled_level;
  logic                           overflow;

  modport source (output valid, rms_level, smoothed_level, scaled_level, overflow,
                  input ready);
  modport sink   (input valid, rms_level, smoothed_level, scaled_level, overflow,
                  output ready);
endinterface

interface srms_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [srms_pkg::CFG_IDX_W-1:0]  index;
  logic [srms_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/srms_datapath.sv
// Datapath: square accumulator, shared divider, root unit, smoothing and output registers.
module srms_datapath #(
  parameter int MAX_FRAMES  = srms_pkg::MaxFramesDefault,
  parameter int SAMPLE_BITS = srms_pkg::SampleBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srms_pkg::cmd_t                      cmd_i,
  output srms_pkg::sts_t                      sts_o,
  input  logic signed [SAMPLE_BITS-1:0]       left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]       right_sample_i,
  input  logic                                cfg_we_i,
  input  logic [srms_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srms_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [srms_pkg::LEVEL_W-1:0]        rms_level_o,
  output logic [srms_pkg::LEVEL_W-1:0]        smoothed_level_o,
  output logic [srms_pkg::LEVEL_W-1:0]        scaled_level_o,
  output logic                                overflow_o
);

  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int SQ_UP      = (SAMPLE_BITS <= 16) ? 32 - 2 * SAMPLE_BITS : 0;
  localparam int SQ_DN      = (SAMPLE_BITS > 16) ? 2 * SAMPLE_BITS - 32 : 0;
  localparam int DCNT_W     = $clog2(srms_pkg::DIV_STEPS + 1);
  localparam int SCNT_W     = $clog2(srms_pkg::SQRT_STEPS + 1);
  localparam int LW         = srms_pkg::LEVEL_W;

  // configuration
  logic [LW-1:0] weight_q, full_scale_q;

  // accumulation
  logic [SAMPLE_BITS-1:0]       mag_l, mag_r;
  logic [2*SAMPLE_BITS-1:0]     prod_l, prod_r;
  logic [srms_pkg::SQ_W-1:0]    sq_l, sq_r, sq_l_q, sq_r_q;
  logic [srms_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]             count_q;
  logic                         add_pending_q, ovf_seen_q, room;

  // divider
  logic [DCNT_W-1:0]            div_cnt_q;
  logic [srms_pkg::DIV_W-1:0]   div_quo_q;
  logic [srms_pkg::DVR_W-1:0]   div_rem_q, div_dvr_q, div_rem_d;
  logic [srms_pkg::DVR_W:0]     div_trial, div_diff;
  logic                         div_ge;
  logic [2*LW-1:0]              sm_scaled;

  // square root
  logic [SCNT_W-1:0]             sq_cnt_q;
  logic [srms_pkg::RAD_W-1:0]    rad_q;
  logic [srms_pkg::ROOT_W-1:0]   root_q;
  logic [srms_pkg::SREM_W-1:0]   srem_q, srem_d;
  logic [srms_pkg::SREM_W+1:0]   srem_t, srem_trial, srem_diff;
  logic                          sq_ge;
  logic [LW-1:0]                 rms_val;

  // smoothing
  logic [srms_pkg::MUL_A_W-1:0]  mul_a;
  logic [LW-1:0]                 mul_b;
  logic [srms_pkg::PROD_W-1:0]   prod, prod_q, acc_q;
  logic [srms_pkg::SMOOTH_W-1:0] total;
  logic [LW-1:0]                 sm_next, sm_q, smoothed_q, scaled_val;

  // output registers
  logic [LW-1:0] rms_out_q, sm_out_q, scaled_out_q;
  logic          ovf_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q     <= srms_pkg::SmoothingWeightReset;
      full_scale_q <= srms_pkg::FullScaleReset;
    end else if (cfg_we_i) begin
      unique case (srms_pkg::cfg_reg_e'(cfg_idx_i))
        srms_pkg::REG_SMOOTHING_WEIGHT: weight_q     <= LW'(cfg_data_i);
        srms_pkg::REG_FULL_SCALE:       full_scale_q <= LW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    mag_l  = left_sample_i[SAMPLE_BITS-1] ? $unsigned(-left_sample_i)
                                          : $unsigned(left_sample_i);
    mag_r  = right_sample_i[SAMPLE_BITS-1] ? $unsigned(-right_sample_i)
                                           : $unsigned(right_sample_i);
    prod_l = mag_l * mag_l;
    prod_r = mag_r * mag_r;
    sq_l   = srms_pkg::SQ_W'((64'(prod_l) << SQ_UP) >> SQ_DN);
    sq_r   = srms_pkg::SQ_W'((64'(prod_r) << SQ_UP) >> SQ_DN);
    room   = count_q < CNT_W'(MAX_FRAMES);
    sum_d  = sum_q + srms_pkg::SUM_W'(sq_l_q) + srms_pkg::SUM_W'(sq_r_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && room) begin
      sq_l_q <= sq_l;
      sq_r_q <= sq_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q         <= '0;
      count_q       <= '0;
      add_pending_q <= 1'b0;
      ovf_seen_q    <= 1'b0;
      smoothed_q    <= '0;
    end else begin
      add_pending_q <= cmd_i.accept && room;
      if (add_pending_q) begin
        sum_q <= sum_d;
      end
      if (cmd_i.accept) begin
        if (room) begin
          count_q <= CNT_W'(count_q + 1'b1);
        end else begin
          ovf_seen_q <= 1'b1;
        end
      end
      if (cmd_i.op == srms_pkg::OP_FINISH) begin
        sum_q      <= '0;
        count_q    <= '0;
        ovf_seen_q <= 1'b0;
        smoothed_q <= sm_q;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    div_trial = {div_rem_q, div_quo_q[srms_pkg::DIV_W-1]};
    div_diff  = div_trial - {1'b0, div_dvr_q};
    div_ge    = div_trial >= {1'b0, div_dvr_q};
    div_rem_d = div_ge ? div_diff[srms_pkg::DVR_W-1:0] : div_trial[srms_pkg::DVR_W-1:0];
    sm_scaled = {sm_q, {LW{1'b0}}} - {{LW{1'b0}}, sm_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.op == srms_pkg::OP_LOAD_RMS || cmd_i.op == srms_pkg::OP_LOAD_SCALE) begin
      div_cnt_q <= DCNT_W'(srms_pkg::DIV_STEPS);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= DCNT_W'(div_cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == srms_pkg::OP_LOAD_RMS) begin
      div_quo_q <= srms_pkg::DIV_W'(sum_q);
      div_rem_q <= '0;
      div_dvr_q <= srms_pkg::DVR_W'({count_q, 1'b0});
    end else if (cmd_i.op == srms_pkg::OP_LOAD_SCALE) begin
      div_quo_q <= srms_pkg::DIV_W'(sm_scaled);
      div_rem_q <= '0;
      div_dvr_q <= full_scale_q;
    end else if (div_cnt_q != '0) begin
      div_quo_q <= {div_quo_q[srms_pkg::DIV_W-2:0], div_ge};
      div_rem_q <= div_rem_d;
    end
  end

  // bitwise square root, one root bit per cycle
  always_comb begin
    srem_t     = {srem_q, rad_q[srms_pkg::RAD_W-1 -: 2]};
    srem_trial = {1'b0, root_q, 2'b01};
    srem_diff  = srem_t - srem_trial;
    sq_ge      = srem_t >= srem_trial;
    srem_d     = sq_ge ? srem_diff[srms_pkg::SREM_W-1:0] : srem_t[srms_pkg::SREM_W-1:0];
    rms_val    = (|root_q[srms_pkg::ROOT_W-1:LW]) ? srms_pkg::LevelMax : root_q[LW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
    end else if (cmd_i.op == srms_pkg::OP_LOAD_SQRT) begin
      sq_cnt_q <= SCNT_W'(srms_pkg::SQRT_STEPS);
    end else if (sq_cnt_q != '0) begin
      sq_cnt_q <= SCNT_W'(sq_cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == srms_pkg::OP_LOAD_SQRT) begin
      rad_q  <= srms_pkg::RAD_W'(div_quo_q);
      root_q <= '0;
      srem_q <= '0;
    end else if (sq_cnt_q != '0) begin
      rad_q  <= {rad_q[srms_pkg::RAD_W-3:0], 2'b00};
      root_q <= {root_q[srms_pkg::ROOT_W-2:0], sq_ge};
      srem_q <= srem_d;
    end
  end

  // moving average on one shared multiplier
  always_comb begin
    if (cmd_i.op == srms_pkg::OP_MUL_NEW) begin
      mul_a = {1'b0, weight_q};
      mul_b = rms_val;
    end else begin
      mul_a = srms_pkg::WeightOne - {1'b0, weight_q};
      mul_b = smoothed_q;
    end
    prod       = mul_a * mul_b;
    total      = {1'b0, acc_q} + {1'b0, prod_q} + srms_pkg::RoundHalf;
    sm_next    = (|total[srms_pkg::SMOOTH_W-1:2*LW]) ? srms_pkg::LevelMax
                                                     : total[2*LW-1:LW];
    scaled_val = (|div_quo_q[srms_pkg::DIV_W-1:LW]) ? srms_pkg::LevelMax
                                                    : div_quo_q[LW-1:0];
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      srms_pkg::OP_MUL_NEW: prod_q <= prod;
      srms_pkg::OP_MUL_OLD: begin
        acc_q  <= prod_q;
        prod_q <= prod;
      end
      srms_pkg::OP_SUM_SMOOTH: sm_q <= sm_next;
      srms_pkg::OP_FINISH: begin
        rms_out_q    <= rms_val;
        sm_out_q     <= sm_q;
        scaled_out_q <= scaled_val;
        ovf_out_q    <= ovf_seen_q;
      end
      default: ;
    endcase
  end

  assign sts_o.div_done   = (div_cnt_q == '0);
  assign sts_o.sqrt_done  = (sq_cnt_q == '0);
  assign rms_level_o      = rms_out_q;
  assign smoothed_level_o = sm_out_q;
  assign scaled_level_o   = scaled_out_q;
  assign overflow_o       = ovf_out_q;

endmodule

>>> rtl/srms_ctrl.sv
// Controller: sequences accumulation, end-of-buffer math and the result handshake.
module srms_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           frame_valid_i,
  input  logic           last_frame_i,
  output logic           frame_ready_o,
  output logic           result_valid_o,
  input  logic           result_ready_i,
  output srms_pkg::cmd_t cmd_o,
  input  srms_pkg::sts_t sts_i
);

  srms_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srms_pkg::ST_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    frame_ready_o = 1'b0;
    cmd_o.accept  = 1'b0;
    cmd_o.op      = srms_pkg::OP_NONE;
    out_valid_d   = out_valid_q && !result_ready_i;
    unique case (state_q)
      srms_pkg::ST_ACCUM: begin
        frame_ready_o = 1'b1;
        cmd_o.accept  = frame_valid_i;
        if (frame_valid_i && last_frame_i) begin
          state_d = srms_pkg::ST_DRAIN;
        end
      end
      srms_pkg::ST_DRAIN: state_d = srms_pkg::ST_LOAD_RMS;
      srms_pkg::ST_LOAD_RMS: begin
        cmd_o.op = srms_pkg::OP_LOAD_RMS;
        state_d  = srms_pkg::ST_DIV_RMS;
      end
      srms_pkg::ST_DIV_RMS: begin
        if (sts_i.div_done) begin
          cmd_o.op = srms_pkg::OP_LOAD_SQRT;
          state_d  = srms_pkg::ST_SQRT;
        end
      end
      srms_pkg::ST_SQRT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.op = srms_pkg::OP_MUL_NEW;
          state_d  = srms_pkg::ST_MUL_OLD;
        end
      end
      srms_pkg::ST_MUL_OLD: begin
        cmd_o.op = srms_pkg::OP_MUL_OLD;
        state_d  = srms_pkg::ST_SUM;
      end
      srms_pkg::ST_SUM: begin
        cmd_o.op = srms_pkg::OP_SUM_SMOOTH;
        state_d  = srms_pkg::ST_LOAD_SCALE;
      end
      srms_pkg::ST_LOAD_SCALE: begin
        cmd_o.op = srms_pkg::OP_LOAD_SCALE;
        state_d  = srms_pkg::ST_DIV_SCALE;
      end
      srms_pkg::ST_DIV_SCALE: begin
        if (sts_i.div_done) begin
          state_d = srms_pkg::ST_OUT;
        end
      end
      srms_pkg::ST_OUT: begin
        if (!out_valid_q || result_ready_i) begin
          cmd_o.op    = srms_pkg::OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = srms_pkg::ST_ACCUM;
        end
      end
      default: state_d = srms_pkg::ST_ACCUM;
    endcase
  end

  assign result_valid_o = out_valid_q;

endmodule

>>> rtl/stereo_rms_level_meter_core.sv
// Top level: stereo RMS level meter with exponential smoothing.
//
//  channel   dir  handshake     payload
//  frame_i   in   valid/ready   left_sample, right_sample, last_frame
//  result_o  out  valid/ready   rms_level, smoothed_level, scaled_level, overflow
//  cfg_i     in   valid/ready   index (0 smoothing weight, 1 full scale), data
//
//  Frames are taken one per cycle while accumulating; squares are summed in the
//  cycle after the item. After a last_frame item no frame is taken in two passes of
//  the 40-step shared divider, 20 steps of the root unit and the multiplier steps.
//  The result sits in an output register; accumulation resumes while it waits.
//  Reset restores the register defaults and clears the sums; cfg_i is always ready.
module stereo_rms_level_meter_core #(
  parameter int MAX_FRAMES  = srms_pkg::MaxFramesDefault,
  parameter int SAMPLE_BITS = srms_pkg::SampleBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  srms_frame_if.sink    frame_i,
  srms_result_if.source result_o,
  srms_cfg_if.sink      cfg_i
);

  srms_pkg::cmd_t cmd;
  srms_pkg::sts_t sts;
  logic           frame_ready, result_valid;

  srms_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_valid_i  (frame_i.valid),
    .last_frame_i   (frame_i.last_frame),
    .frame_ready_o  (frame_ready),
    .result_valid_o (result_valid),
    .result_ready_i (result_o.ready),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  srms_datapath #(
    .MAX_FRAMES  (MAX_FRAMES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .left_sample_i    (frame_i.left_sample),
    .right_sample_i   (frame_i.right_sample),
    .cfg_we_i         (cfg_i.valid),
    .cfg_idx_i        (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .rms_level_o      (result_o.rms_level),
    .smoothed_level_o (result_o.smoothed_level),
    .scaled_level_o   (result_o.scaled_level),
    .overflow_o       (result_o.overflow)
  );

  assign frame_i.ready  = frame_ready;
  assign result_o.valid = result_valid;
  assign cfg_i.ready    = 1'b1;

endmodule
